// File: sv/f2i_pkg.sv
// Shared types and constants for the binary64 to int64 converter.
package f2i_pkg;

    localparam int DATA_W = 64;
    localparam int FRAC_W = 52;
    localparam int EXP_W = 11;
    localparam int CMD_W = 2;
    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
    localparam int EXP_BIAS_INT = 1075;

    typedef enum logic [CMD_W-1:0] {
        CMD_FLOOR = 2'd0,
        CMD_CEIL = 2'd1,
        CMD_NEAREST = 2'd2,
        CMD_NEAREST_ALT = 2'd3
    } cmd_t;

    // Decoded operand, passed from the unpack stage to the shift stage.
    typedef struct packed {
        logic neg;
        logic special;        // status forced to 1 or int minimum
        logic is_min;         // exactly minus two to the 63
        logic left;           // integer part exact, shift left
        logic [5:0] shamt;    // shift amount (left or right)
        logic far;            // right shift of 64 or more
        logic [52:0] mant;
        logic nearest;
        logic ceil_cmd;
    } dec_t;

    // Shifted magnitude with rounding information.
    typedef struct packed {
        logic neg;
        logic special;
        logic is_min;
        logic [63:0] mag;
        logic inexact;
        logic above_half;
        logic eq_half;
        logic nearest;
        logic ceil_cmd;
    } shf_t;

endpackage

// File: sv/f2i_unpack.sv
// Stage one: field decode and shift amount of the binary64 operand.
module f2i_unpack (
    input  logic [1:0] cmd,
    input  logic [63:0] value_bits,
    output f2i_pkg::dec_t dec
);
    logic [10:0] bexp;
    logic [12:0] e_val;
    logic [12:0] rsh;

    always_comb begin
        bexp = value_bits[62:52];
        dec = '0;
        dec.neg = value_bits[63];
        dec.mant = {(bexp != 11'd0), value_bits[51:0]};
        dec.nearest = cmd[1];
        dec.ceil_cmd = (cmd == f2i_pkg::CMD_CEIL);
        // e = max(bexp,1) - 1075, kept as 13-bit two's complement.
        e_val = {2'b00, ((bexp != 11'd0) ? bexp : 11'd1)}
            - 13'(f2i_pkg::EXP_BIAS_INT);
        rsh = 13'd0 - e_val;
        if (bexp == f2i_pkg::EXP_ALL_ONES) begin
            dec.special = 1'b1;
        end else if (!e_val[12]) begin
            if (e_val >= 13'd11) begin
                dec.special = 1'b1;
                dec.is_min = (e_val == 13'd11) && value_bits[63]
                    && (value_bits[51:0] == 52'd0);
            end else begin
                dec.left = 1'b1;
                dec.shamt = e_val[5:0];
            end
        end else begin
            dec.far = (rsh >= 13'd64);
            dec.shamt = rsh[5:0];
        end
    end
endmodule

// File: sv/f2i_shift.sv
// Stage two: align the significand and extract the rounding bits.
module f2i_shift (
    input  f2i_pkg::dec_t dec,
    output f2i_pkg::shf_t shf
);
    logic [116:0] wide;
    logic [63:0] rem;
    logic [63:0] half;

    always_comb begin
        shf = '0;
        shf.neg = dec.neg;
        shf.special = dec.special;
        shf.is_min = dec.is_min;
        shf.nearest = dec.nearest;
        shf.ceil_cmd = dec.ceil_cmd;
        // Significand placed above a 64-bit fraction field.
        wide = {dec.mant, 64'd0} >> dec.shamt;
        rem = wide[63:0];
        half = 64'h8000_0000_0000_0000;
        if (dec.left) begin
            shf.mag = {11'd0, dec.mant} << dec.shamt;
        end else if (dec.far) begin
            shf.inexact = (dec.mant != 53'd0);
        end else begin
            shf.mag = {11'd0, wide[116:64]};
            shf.inexact = (rem != 64'd0);
            shf.above_half = (rem > half);
            shf.eq_half = (rem == half);
        end
    end
endmodule

// File: sv/f2i_round.sv
// Stage three: round increment, sign and error result.
module f2i_round (
    input  f2i_pkg::shf_t shf,
    output logic signed [63:0] int_result,
    output logic status
);
    logic up;
    logic [63:0] mag;

    always_comb begin
        if (!shf.inexact) begin
            up = 1'b0;
        end else if (shf.nearest) begin
            up = shf.above_half || (shf.eq_half && shf.mag[0]);
        end else if (shf.ceil_cmd) begin
            up = !shf.neg;
        end else begin
            up = shf.neg;
        end
        mag = shf.mag + {63'd0, up};
        if (shf.special) begin
            status = !shf.is_min;
            int_result = shf.is_min ? 64'sh8000_0000_0000_0000 : 64'sd0;
        end else begin
            status = 1'b0;
            int_result = shf.neg ? $signed(64'd0 - mag) : $signed(mag);
        end
    end
endmodule

// File: sv/float_to_int_rounding_converter.sv
// Top level of the pipelined binary64 to int64 rounding converter.
// Usage: present a word on s_valid with s_cmd (0 floor, 1 ceiling,
// 2 or 3 nearest ties to even) and s_value_bits (raw binary64 pattern).
// The result word on the m_ side carries m_int_result and m_status;
// status is 1 for NaN, infinity or a rounded value outside int64,
// and the integer is then zero. Exactly minus two to the 63 converts.
// The pipeline has three register stages: decode, align, round. A word
// accepted moves through the decode, align and round registers in order
// and raises m_valid once it is in the round register. One word is taken every
// cycle while the output side keeps up.
// Each stage holds a valid bit; a stage advances when it is empty or
// the stage after it advances, so a stall at m_ready freezes the full
// stages in place and backs up to s_ready with no loss or repeat.
// Empty stages keep filling during a stall (bubbles collapse).
// Reset (aresetn low, synchronous) clears all valid bits; payload
// registers hold whatever they had.
module float_to_int_rounding_converter (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic [1:0] s_cmd,
    input  logic [63:0] s_value_bits,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [63:0] m_int_result,
    output logic m_status
);
    logic v1_reg, v2_reg, v3_reg;
    f2i_pkg::dec_t dec_next, dec_reg;
    f2i_pkg::shf_t shf_next, shf_reg;
    logic signed [63:0] res_next, res_reg;
    logic st_next, st_reg;
    logic en1, en2, en3;

    f2i_unpack u_unpack (.cmd(s_cmd), .value_bits(s_value_bits), .dec(dec_next));
    f2i_shift u_shift (.dec(dec_reg), .shf(shf_next));
    f2i_round u_round (.shf(shf_reg), .int_result(res_next), .status(st_next));

    // Each stage loads when it is empty or its content moves on.
    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) dec_reg <= dec_next;
        if (en2) shf_reg <= shf_next;
        if (en3) begin
            res_reg <= res_next;
            st_reg <= st_next;
        end
    end

    assign m_valid = v3_reg;
    assign m_int_result = res_reg;
    assign m_status = st_reg;

    // An error result always carries a zero integer.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_int_result == 64'sd0))
        else $error("error word with nonzero integer");

    // A stalled result word holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_int_result) && $stable(m_status)))
        else $error("stalled result changed");

    // A word accepted into an empty pipe reaches the output after the decode, align and round registers.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !v1_reg && !v2_reg && !v3_reg) |=> ##2 m_valid)
        else $error("latency mismatch");
endmodule
